### sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and codes of the LFU cache table
// Operation codes, sequencer states and update modes.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Operation codes carried in the func field of a request
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // What the update sweep does to the table
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TOUCH,
    MODE_EVICT,
    MODE_FILL
  } mode_t;

endpackage

### sv/lfu_ifs.sv
// ----------------------------------------------------------------------------
// lfu_ifs: request and response channels of the LFU cache table
// Valid/ready handshake; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] lookup_key;
  logic signed [31:0] store_value;

  modport source (output valid, func, lookup_key, store_value, input ready);
  modport sink (input valid, func, lookup_key, store_value, output ready);
endinterface

interface lfu_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;
  logic signed [31:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### sv/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram: entry memory of the LFU cache table
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 84,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with LFU replacement and LRU tie break
// Entries live in one synchronous RAM; valid bits and occupancy in flops.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+-----------------------------------------------
//  req       | in        | func, lookup_key, store_value
//  rsp       | out       | hit, read_value, evicted, evicted_key
//  capacity  | in        | capacity_we, capacity_wdata (entries allowed)
//
//  The response follows one read sweep over the entry RAM, which finds the
//  key and the victim, when the operation leaves the table as it is (get
//  miss, put with zero capacity); otherwise a second read-modify-write sweep
//  moves the recency ranks and counts first. The sequencer passes back
//  through ST_IDLE after each operation, so a new request is not taken
//  before the previous one has reached ST_DONE and the output register.
//  Reset clears valid bits and occupancy at once; capacity resets to 16.
//  A finished response waits in the output register; the next request is
//  taken meanwhile, and its response waits until the previous one is taken.
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            capacity_we,
  input  logic [4:0]      capacity_wdata,
  lfu_req_if.sink         req,
  lfu_rsp_if.source       rsp
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int RANK_W = IDX_W;
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  logic [4:0]          cap_reg;
  logic [CNT_W-1:0]    occupancy;
  logic [CAPACITY-1:0] valid;

  logic                op_func;
  logic [31:0]         op_key;
  logic [31:0]         op_value;

  logic [CNT_W-1:0]    idx;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_slot;

  logic                match_found;
  logic [IDX_W-1:0]    match_slot;
  logic [RANK_W-1:0]   match_rank;
  logic [31:0]         match_value;
  logic                vic_found;
  logic [IDX_W-1:0]    vic_slot;
  logic [RANK_W-1:0]   vic_rank;
  logic [COUNT_BITS-1:0] vic_count;
  logic [31:0]         vic_key;
  logic                free_found;
  logic [IDX_W-1:0]    free_slot;

  mode_t               mode, mode_next;
  logic [IDX_W-1:0]    tgt_slot;
  logic [RANK_W-1:0]   tgt_rank;

  logic                res_hit;
  logic [31:0]         res_read;
  logic                res_ev;
  logic [31:0]         res_evk;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              ram_wdata, ram_q;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [CMP_W-1:0]    cap_ext, cap_eff;
  logic                sweep_last, sweep_done, out_free;
  logic                req_take;

  assign cap_ext    = CMP_W'(cap_reg);
  assign cap_eff    = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  assign sweep_last = (idx == CNT_W'(CAPACITY));
  assign sweep_done = sweep_last && !rd_pend;
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == ST_IDLE);
  assign req_take   = req.valid && req.ready;
  assign ram_q      = entry_t'(ram_rdata);

  lfu_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (rd_slot),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata  (ram_rdata)
  );

  // Decide the update from the scan results
  always_comb begin
    mode_next = MODE_NONE;
    if (op_func == FUNC_GET) begin
      mode_next = match_found ? MODE_TOUCH : MODE_NONE;
    end else if (cap_eff != '0) begin
      if (match_found) begin
        mode_next = MODE_TOUCH;
      end else if (CMP_W'(occupancy) >= cap_eff) begin
        mode_next = MODE_EVICT;
      end else begin
        mode_next = MODE_FILL;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_SCAN;
      ST_SCAN:   if (sweep_done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (mode_next == MODE_NONE) ? ST_DONE : ST_UPDATE;
      ST_UPDATE: if (sweep_done) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM control and write-back data
  always_comb begin
    ram_re    = ((state == ST_SCAN) || (state == ST_UPDATE)) && !sweep_last;
    ram_raddr = idx[IDX_W-1:0];
    ram_we    = (state == ST_UPDATE) && rd_pend && (valid[rd_slot] || (rd_slot == tgt_slot));
    ram_wdata = ram_q;
    if (rd_slot == tgt_slot) begin
      ram_wdata.rank = '0;
      if (mode == MODE_TOUCH) begin
        if (op_func == FUNC_PUT) ram_wdata.value = op_value;
        if (ram_q.count != COUNT_MAX) ram_wdata.count = ram_q.count + 1'b1;
      end else begin
        ram_wdata.key   = op_key;
        ram_wdata.value = op_value;
        ram_wdata.count = COUNT_BITS'(1);
      end
    end else begin
      case (mode)
        MODE_TOUCH: if (ram_q.rank < tgt_rank) ram_wdata.rank = ram_q.rank + 1'b1;
        MODE_EVICT: if (ram_q.rank <= tgt_rank) ram_wdata.rank = ram_q.rank + 1'b1;
        MODE_FILL:  ram_wdata.rank = ram_q.rank + 1'b1;
        default:    ram_wdata.rank = ram_q.rank;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap_reg   <= 5'd16;
      occupancy <= '0;
      valid     <= '0;
      rsp.valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= ram_re;
      if (capacity_we) cap_reg <= capacity_wdata;
      if (state == ST_DECIDE && mode_next == MODE_FILL) occupancy <= occupancy + 1'b1;
      if (ram_we && rd_slot == tgt_slot) valid[rd_slot] <= 1'b1;
      // hold the response until taken, load the next one when free
      if (state == ST_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath: request capture, sweep index, scan tracking
  always_ff @(posedge clk) begin
    if (req_take) begin
      op_func     <= req.func;
      op_key      <= req.lookup_key;
      op_value    <= req.store_value;
      match_found <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
    end
    if (state == ST_IDLE || state == ST_DECIDE) begin
      idx <= '0;
    end else if (ram_re) begin
      idx <= idx + 1'b1;
    end
    rd_slot <= idx[IDX_W-1:0];

    // track the key match, the victim and the first free slot
    if (state == ST_SCAN && rd_pend) begin
      if (valid[rd_slot]) begin
        if (ram_q.key == op_key) begin
          match_found <= 1'b1;
          match_slot  <= rd_slot;
          match_rank  <= ram_q.rank;
          match_value <= ram_q.value;
        end
        if (!vic_found || ram_q.count < vic_count ||
            (ram_q.count == vic_count && ram_q.rank > vic_rank)) begin
          vic_found <= 1'b1;
          vic_slot  <= rd_slot;
          vic_rank  <= ram_q.rank;
          vic_count <= ram_q.count;
          vic_key   <= ram_q.key;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_slot;
      end
    end

    // latch the update plan and the response fields
    if (state == ST_DECIDE) begin
      mode     <= mode_next;
      tgt_slot <= (mode_next == MODE_TOUCH) ? match_slot :
                  (mode_next == MODE_EVICT) ? vic_slot : free_slot;
      tgt_rank <= (mode_next == MODE_TOUCH) ? match_rank : vic_rank;
      res_hit  <= match_found;
      res_read <= (op_func == FUNC_GET) ? (match_found ? match_value : MISS_VALUE) : 32'd0;
      res_ev   <= (mode_next == MODE_EVICT);
      res_evk  <= (mode_next == MODE_EVICT) ? vic_key : 32'd0;
    end

    if (state == ST_DONE && out_free) begin
      rsp.hit         <= res_hit;
      rsp.read_value  <= res_read;
      rsp.evicted     <= res_ev;
      rsp.evicted_key <= res_evk;
    end
  end

endmodule

### sv/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker: port-level checks on the LFU cache table
// Watches the response channel; bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] read_value,
  input logic        evicted,
  input logic [31:0] evicted_key
);

  // Hold a stalled response
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(evicted_key) && $stable(read_value))
    else $error("stalled response changed");

  // Drop no eviction key when nothing was evicted
  a_evk: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == 32'd0)
    else $error("evicted_key set without eviction");

  // Evict only on a put miss
  a_ev_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit && read_value == 32'd0)
    else $error("eviction on hit or get");

  // A miss reads either -1 (get) or 0 (put)
  a_miss_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == 32'hFFFF_FFFF || read_value == 32'd0)
    else $error("miss returned a stored value");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .hit         (rsp.hit),
  .read_value  (rsp.read_value),
  .evicted     (rsp.evicted),
  .evicted_key (rsp.evicted_key)
);

### tb/lfu_cache_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_tb: self-checking bench for the LFU cache table
// Requests from a queue go in through a randomly stalling driver; a monitor
// checks every response against an in-bench LFU/LRU table model.
// ----------------------------------------------------------------------------
module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int SLOTS   = 16;
  localparam int CNT_MAX = 65535;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic capacity_we = 1'b0;
  logic [4:0] capacity_wdata = 5'd0;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_cache_table i_dut (
    .clk(clk), .rst(rst), .capacity_we(capacity_we),
    .capacity_wdata(capacity_wdata), .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  // Model of the table
  logic        m_valid [SLOTS];
  logic [31:0] m_key   [SLOTS];
  logic [31:0] m_val   [SLOTS];
  int          m_cnt   [SLOTS];
  int          m_rank  [SLOTS];
  int          m_occ;
  int          m_cap;

  op_t      op_queue [$];
  outcome_t outcome_queue [$];
  logic [31:0] key_pool [$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  req_acc = 1'b0;
  int  req_hold = 0;
  int  rsp_hold = 0;

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void use_slot(int s);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && i != s && m_rank[i] < m_rank[s]) m_rank[i]++;
    m_rank[s] = 0;
    if (m_cnt[s] < CNT_MAX) m_cnt[s]++;
  endfunction

  function automatic outcome_t predict_lookup(op_t o);
    outcome_t r;
    int s, v, slot, c;
    r = '0;
    c = (m_cap > SLOTS) ? SLOTS : m_cap;
    s = find_slot(o.key);
    r.hit = (s >= 0);
    if (o.func == FUNC_GET) begin
      if (s >= 0) begin
        r.read_value = m_val[s];
        use_slot(s);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (c != 0) begin
      if (s >= 0) begin
        m_val[s] = o.value;
        use_slot(s);
      end else begin
        slot = -1;
        if (m_occ >= c) begin
          v = -1;
          for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && (v < 0 || m_cnt[i] < m_cnt[v] ||
                (m_cnt[i] == m_cnt[v] && m_rank[i] > m_rank[v]))) v = i;
          if (v >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = m_key[v];
            m_valid[v] = 1'b0;
            for (int i = 0; i < SLOTS; i++)
              if (m_valid[i] && m_rank[i] > m_rank[v]) m_rank[i]--;
            m_occ--;
            slot = v;
          end
        end
        if (slot < 0)
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!m_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (m_valid[i]) m_rank[i]++;
          m_valid[slot] = 1'b1;
          m_key[slot] = o.key;
          m_val[slot] = o.value;
          m_cnt[slot] = 1;
          m_rank[slot] = 0;
          m_occ++;
        end
      end
    end
    return r;
  endfunction

  // Input monitor: predict each request at the edge that accepts it
  always @(posedge clk) begin
    req_acc <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      outcome_queue.push_back(predict_lookup(op_queue.pop_front()));
    end
  end

  // Driver: present queued requests, stall in random bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (req_hold > 0) begin
        req_hold <= req_hold - 1;
        req.valid <= 1'b0;
      end else if (!(req.valid && !req_acc) && !quiet && $urandom_range(0, 19) == 0) begin
        req_hold <= $urandom_range(1, 18) - 1;
        req.valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        req.valid <= 1'b1;
        req.func <= op_queue[0].func;
        req.lookup_key <= op_queue[0].key;
        req.store_value <= op_queue[0].value;
      end else begin
        req.valid <= 1'b0;
      end
      // stall the response side independently
      if (rsp_hold > 0) begin
        rsp_hold <= rsp_hold - 1;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        rsp_hold <= $urandom_range(1, 18) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each response with the oldest prediction
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key};
      if (outcome_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        want = outcome_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit %b/%b rd %h/%h ev %b/%b evk %h/%h",
                     want.hit, got.hit, want.read_value, got.read_value,
                     want.evicted, got.evicted, want.evicted_key, got.evicted_key);
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic add_op(logic f, logic [31:0] k, logic [31:0] v);
    op_t o;
    o.func = f; o.key = k; o.value = v;
    op_queue.push_back(o);
  endtask

  task automatic drain();
    while (op_queue.size() > 0 || outcome_queue.size() > 0 || req.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_capacity(int c);
    @(negedge clk);
    capacity_we <= 1'b1;
    capacity_wdata <= c[4:0];
    @(negedge clk);
    capacity_we <= 1'b0;
    m_cap = c;
  endtask

  // Random phase: a working set of keys sized around the capacity
  task automatic random_phase(int n);
    key_pool.delete();
    repeat ($urandom_range(4, 28)) key_pool.push_back($urandom());
    for (int i = 0; i < n; i++)
      add_op(($urandom_range(0, 1) == 1) ? FUNC_PUT : FUNC_GET, pick_key(), $urandom());
    drain();
  endtask

  initial begin
    int caps [6];
    caps = '{1, 0, 5, 31, 17, 3};
    for (int i = 0; i < SLOTS; i++) begin
      m_valid[i] = 1'b0; m_key[i] = '0; m_val[i] = '0; m_cnt[i] = 0; m_rank[i] = 0;
    end
    m_occ = 0;
    m_cap = 16;
    req.valid = 1'b0; req.func = FUNC_GET; req.lookup_key = '0; req.store_value = '0;
    rsp.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, miss, hit, overwrite, fill and evict
    add_op(FUNC_GET, 32'h8000_0000, 32'h0);
    add_op(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_op(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_op(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(FUNC_PUT, 32'h0, 32'h0);
    add_op(FUNC_GET, 32'h8000_0000, 32'h1234);
    add_op(FUNC_PUT, 32'h7FFF_FFFF, 32'h55);
    add_op(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
    for (int i = 1; i <= 14; i++) add_op(FUNC_PUT, i, ~i);
    add_op(FUNC_GET, 32'h0, 32'h0);
    add_op(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    drain();

    random_phase(60);

    // Capacity sweep including zero, above range and lowering below occupancy
    foreach (caps[j]) begin
      set_capacity(caps[j]);
      random_phase(170);
    end
    set_capacity(16);
    random_phase(150);
    quiet = 1'b1;
    random_phase(100);

    if (mismatches == 0 && outcome_queue.size() == 0) begin
      $display("PASS lfu_cache_table");
    end else begin
      $display("FAIL lfu_cache_table");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL lfu_cache_table");
    $finish;
  end

endmodule

### files.f
sv/lfu_pkg.sv
sv/lfu_ifs.sv
sv/lfu_ram.sv
sv/lfu_cache_table.sv
sv/lfu_checker.sv
tb/lfu_cache_table_tb.sv
